FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file ccw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concurrent assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concurrent assertion failed");

`endif

FILE: rtl/ccw_pkg.sv
package ccw_pkg;

    // fixed field widths
    localparam int COIN_BITS   = 16;
    localparam int TARGET_BITS = 10;
    localparam int OUT_BITS    = 32;

    // commands from the sequencer to the table datapath
    typedef struct packed {
        logic rd;        // read both table ports
        logic wr_sum;    // write the saturated sum
        logic wr_clr;    // write the cleared value
        logic clr_flag;  // clear the sticky overflow flag
    } t_tbl_cmd;

endpackage

FILE: rtl/coin_change_way_counter.sv
// Coin change way counter. Write the target amount through i_cfg_we/i_cfg_data while
// busy is low, then issue one coin denomination per start pulse (taken when start is
// high and busy is low); mark the final coin with i_last_coin. Each coin c runs one
// read-add-write pass over table entries c..target through a single saturating adder,
// one entry per cycle, with busy high through the pass and S_DRAIN (no pass when c is
// zero or above the target). After the last coin S_READ reads entry target and S_OUT
// registers the count, which appears on o_way_count/o_count_overflow with o_done high
// for exactly one cycle; the receiver cannot stall it. After reset and after every
// result the table is reset (entry 0 to one, others to zero) over all MAX_TARGET + 1
// entries, one per cycle, with busy high; configuration writes are still taken then.
module coin_change_way_counter #(
    parameter int MAX_TARGET = 1023,
    parameter int COUNT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ccw_pkg::TARGET_BITS-1:0] i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [ccw_pkg::COIN_BITS-1:0]   i_coin_value,
    input  logic                            i_last_coin,
    output logic                            o_done,
    output logic [ccw_pkg::OUT_BITS-1:0]    o_way_count,
    output logic                            o_count_overflow
);
    import ccw_pkg::*;

    localparam int DEPTH = MAX_TARGET + 1;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PASS  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [AW-1:0]          r_addr, n_addr;
    logic [AW-1:0]          r_coin, n_coin;
    logic [AW-1:0]          r_tgt, n_tgt;
    logic                   r_last, n_last;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_wr_addr, n_wr_addr;
    logic [TARGET_BITS-1:0] r_target;
    logic                   r_done, n_done;
    logic [OUT_BITS-1:0]    r_way, n_way;
    logic                   r_ovf_out, n_ovf_out;

    t_tbl_cmd               cmd;
    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_BITS-1:0]  tbl_data;
    logic                   tbl_ovf;
    logic [31:0]            tgt32;
    logic [AW-1:0]          eff_tgt;
    logic                   coin_ok;
    logic                   accept;
    logic [63:0]            cnt64;
    logic                   clip;

    // effective target and coin check for an arriving transaction
    always_comb begin
        tgt32   = 32'(r_target);
        eff_tgt = AW'((tgt32 > MAX_TARGET) ? MAX_TARGET : tgt32);
        coin_ok = (i_coin_value != '0) && (32'(i_coin_value) <= 32'(eff_tgt));
        accept  = start && (r_state == S_IDLE);
    end

    // result clipping to the output width
    always_comb begin
        cnt64 = 64'(tbl_data);
        clip  = cnt64 > 64'h0000_0000_FFFF_FFFF;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_coin    = r_coin;
        n_tgt     = r_tgt;
        n_last    = r_last;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_done    = 1'b0;
        n_way     = r_way;
        n_ovf_out = r_ovf_out;
        cmd       = '0;
        rd_addr_a = r_addr;
        rd_addr_b = r_addr - r_coin;
        wr_addr   = r_wr_addr;
        unique case (r_state)
            S_CLEAR: begin
                cmd.wr_clr   = 1'b1;
                cmd.clr_flag = 1'b1;
                wr_addr      = r_addr;
                n_addr       = r_addr + AW'(1);
                if (r_addr == AW'(MAX_TARGET)) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_coin = AW'(i_coin_value);
                    n_tgt  = eff_tgt;
                    n_last = i_last_coin;
                    if (coin_ok) begin
                        n_state = S_PASS;
                        n_addr  = AW'(i_coin_value);
                    end else if (i_last_coin) begin
                        n_state = S_READ;
                    end
                end
            end
            S_PASS: begin
                // read entry v now, write its sum in the next cycle
                cmd.rd     = 1'b1;
                cmd.wr_sum = r_pend;
                n_pend     = 1'b1;
                n_wr_addr  = r_addr;
                n_addr     = r_addr + AW'(1);
                if (r_addr == r_tgt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                cmd.wr_sum = r_pend;
                n_pend     = 1'b0;
                n_state    = r_last ? S_READ : S_IDLE;
            end
            S_READ: begin
                cmd.rd    = 1'b1;
                rd_addr_a = r_tgt;
                n_state   = S_OUT;
            end
            S_OUT: begin
                n_done    = 1'b1;
                n_way     = clip ? '1 : cnt64[OUT_BITS-1:0];
                n_ovf_out = tbl_ovf || clip;
                n_state   = S_CLEAR;
                n_addr    = '0;
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
            r_target <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_coin    <= n_coin;
        r_tgt     <= n_tgt;
        r_last    <= n_last;
        r_wr_addr <= n_wr_addr;
        r_way     <= n_way;
        r_ovf_out <= n_ovf_out;
    end

    ccw_table #(
        .MAX_TARGET (MAX_TARGET),
        .COUNT_BITS (COUNT_BITS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_wr_addr   (wr_addr),
        .o_rd_data   (tbl_data),
        .o_ovf       (tbl_ovf)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_way_count      = r_way;
    assign o_count_overflow = r_ovf_out;

endmodule

FILE: rtl/ccw_table.sv
module ccw_table #(
    parameter int MAX_TARGET = 1023,
    parameter int COUNT_BITS = 32,
    localparam int DEPTH = MAX_TARGET + 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccw_pkg::t_tbl_cmd     i_cmd,
    input  logic [AW-1:0]         i_rd_addr_a,
    input  logic [AW-1:0]         i_rd_addr_b,
    input  logic [AW-1:0]         i_wr_addr,
    output logic [COUNT_BITS-1:0] o_rd_data,
    output logic                  o_ovf
);
    import ccw_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_a;
    logic [COUNT_BITS-1:0] r_rd_b;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic                  r_fwd;
    logic                  r_ovf;
    logic [COUNT_BITS-1:0] rd_b_eff;
    logic [COUNT_BITS:0]   sum_full;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [COUNT_BITS-1:0] wr_data;

    // shared saturating adder, lower operand bypassed when it was just written
    always_comb begin
        rd_b_eff = r_fwd ? r_fwd_data : r_rd_b;
        sum_full = {1'b0, r_rd_a} + {1'b0, rd_b_eff};
        sum_sat  = sum_full[COUNT_BITS] ? '1 : sum_full[COUNT_BITS-1:0];
        if (i_cmd.wr_sum) begin
            wr_data = sum_sat;
        end else begin
            wr_data = (i_wr_addr == '0) ? COUNT_BITS'(1) : '0;
        end
    end

    // table memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sum || i_cmd.wr_clr) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
        r_fwd_data <= sum_sat;
    end

    // bypass flag and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
            r_ovf <= 1'b0;
        end else begin
            r_fwd <= i_cmd.wr_sum && i_cmd.rd && (i_rd_addr_b == i_wr_addr);
            if (i_cmd.clr_flag) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.wr_sum && sum_full[COUNT_BITS]) begin
                r_ovf <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_a;
    assign o_ovf     = r_ovf;

endmodule

FILE: rtl/ccw_checker.sv
`include "assert_macros.svh"

module ccw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // a result lasts a single cycle
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

    // the table sweep is running while a result is shown
    `ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy)

    // a newly taken transaction never yields a result on the next cycle
    `ASSERT_NEXT(a_no_early_done, i_clk, i_rst_n, start && !busy, !o_done)

endmodule

bind coin_change_way_counter ccw_checker u_ccw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
